FILE: hdl/pressure_temperature_compensation_defines.svh
// Assertion macros shared by the compensation checker.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

// Check a property every cycle outside reset.
`define PTC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property that carries its own reset handling.
`define PTC_ASSERT_RAW(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: hdl/ptc_pkg.sv
// Constants shared by the pressure and temperature compensation block.
`default_nettype none
package ptc_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_TEMP_CALIB = 3'd0;
   localparam logic [2:0] CSR_P1_P2      = 3'd1;
   localparam logic [2:0] CSR_P3_P4      = 3'd2;
   localparam logic [2:0] CSR_P5_P6      = 3'd3;
   localparam logic [2:0] CSR_P7_P8      = 3'd4;
   localparam logic [2:0] CSR_P9         = 3'd5;
   localparam logic [2:0] CSR_P10_P11    = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 40;

   // Pipeline depth from request register to response register
   localparam int STAGES = 14;

   // ceil(2^51 / 10): exact quotient by ten for magnitudes below 2^47
   localparam logic [47:0] RECIP_TEN = 48'd225179981368525;

   localparam logic [24:0]        PRESS_MAX = 25'h1FFFFFF;
   localparam logic signed [15:0] TEMP_MAX  = 16'sh7FFF;
   localparam logic signed [15:0] TEMP_MIN  = 16'sh8000;

endpackage
`default_nettype wire

FILE: hdl/pressure_temperature_compensation.sv
// Top level: pipelined integer compensation of raw temperature and pressure.
// Throughput: one request per cycle; the 14-stage datapath advances as a whole,
// and a stalled response holds every stage (req_ready is low only while it is held).
// Configuration writes are never stalled (csr_ready is always high).
// Reset empties the pipeline and clears all calibration registers to zero.
`default_nettype none
module pressure_temperature_compensation (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [23:0]                         req_raw_temperature,
   input  wire logic [23:0]                         req_raw_pressure,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [15:0]                       rsp_temperature_centi_c,
   output logic [24:0]                              rsp_pressure_centi_pa,
   output logic                                     rsp_out_of_range,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ptc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ptc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Calibration registers
   logic [39:0] temp_calib_ff;
   logic [31:0] p1p2_ff;
   logic [15:0] p3p4_ff;
   logic [31:0] p5p6_ff;
   logic [15:0] p7p8_ff;
   logic [15:0] p9_ff;
   logic [15:0] p10p11_ff;

   logic [15:0]        t1;
   logic [15:0]        t2;
   logic signed [7:0]  t3;
   logic signed [15:0] p1;
   logic signed [15:0] p2;
   logic signed [7:0]  p3;
   logic signed [7:0]  p4;
   logic [15:0]        p5;
   logic [15:0]        p6;
   logic signed [7:0]  p7;
   logic signed [7:0]  p8;
   logic signed [15:0] p9;
   logic signed [7:0]  p10;
   logic signed [7:0]  p11;
   logic signed [16:0] p1m;
   logic signed [16:0] p2m;

   logic [ptc_pkg::STAGES-1:0] vld_ff;
   logic                       adv;

   // Carried along the pipe
   logic [23:0]        rp_pipe_ff [1:10];
   logic signed [15:0] temp_pipe_ff [4:13];
   logic               tflag_pipe_ff [4:13];
   logic               qneg_pipe_ff [6:9];
   logic signed [46:0] p6tl_pipe_ff [4:8];
   logic signed [46:0] p2tl_pipe_ff [4:8];
   logic signed [63:0] p7sq_pipe_ff [5:8];
   logic signed [63:0] p3sq_pipe_ff [5:8];
   logic signed [56:0] cub_pipe_ff [9:12];
   logic signed [61:0] offs4_pipe_ff [10:11];

   // Stage registers and their next values
   logic signed [25:0] s1_a_in;
   logic signed [42:0] s1_ta_in, s1_ta_ff;
   logic signed [52:0] s1_aa_in, s1_aa_ff;
   logic signed [61:0] s2_x_in, s2_x_ff;
   logic signed [61:0] s3_xa;
   logic signed [29:0] s3_tl_in, s3_tl_ff;
   logic signed [59:0] s4_sq_in, s4_sq_ff;
   logic signed [29:0] s4_tl_ff;
   logic signed [35:0] s4_tc25;
   logic signed [35:0] s4_tca;
   logic signed [21:0] s4_tc;
   logic signed [15:0] s4_temp_in;
   logic               s4_tflag_in;
   logic signed [46:0] s4_p6tl_in;
   logic signed [46:0] s4_p2tl_in;
   logic signed [39:0] s4_pq_in, s4_pq_ff;
   logic signed [54:0] s5_pl_in, s5_pl_ff;
   logic signed [54:0] s5_ph_in, s5_ph_ff;
   logic signed [63:0] s5_p7sq_in;
   logic signed [63:0] s5_p3sq_in;
   logic signed [63:0] s5_qx_in, s5_qx_ff;
   logic [47:0]        s5_rr_in, s5_rr_ff;
   logic signed [63:0] s6_cprod;
   logic signed [63:0] s6_cadj;
   logic signed [55:0] s6_cube_in, s6_cube_ff;
   logic [63:0]        s6_qabs;
   logic [46:0]        s6_m_in, s6_m_ff;
   logic signed [56:0] s6_p11rr_in, s6_p11rr_ff;
   logic signed [63:0] s7_p8c_in, s7_p8c_ff;
   logic signed [63:0] s7_p4c_in, s7_p4c_ff;
   logic [47:0]        s7_pll_in, s7_pll_ff;
   logic [47:0]        s7_plh_in, s7_plh_ff;
   logic [46:0]        s7_phl_in, s7_phl_ff;
   logic [46:0]        s7_phh_in, s7_phh_ff;
   logic signed [56:0] s7_p11adj;
   logic signed [40:0] s7_c1_in, s7_c1_ff;
   logic signed [63:0] s8_p8a;
   logic signed [63:0] s8_p4a;
   logic signed [58:0] s8_p8c32_in, s8_p8c32_ff;
   logic signed [58:0] s8_p4c32_in, s8_p4c32_ff;
   logic [94:0]        s8_rsum;
   logic [43:0]        s8_q_in, s8_q_ff;
   logic signed [63:0] s8_c1rp_in, s8_c1rp_ff;
   logic signed [63:0] s9_offs_in, s9_offs_ff;
   logic signed [63:0] s9_sens_in, s9_sens_ff;
   logic [63:0]        s9_qrp_in, s9_qrp_ff;
   logic signed [63:0] s9_ca;
   logic [63:0]        s10_qv_in, s10_qv_ff;
   logic signed [63:0] s10_oa;
   logic signed [63:0] s10_sa;
   logic signed [39:0] s10_s24_in, s10_s24_ff;
   logic [63:0]        s11_qva;
   logic signed [54:0] s11_q3_in, s11_q3_ff;
   logic signed [63:0] s11_lin_in, s11_lin_ff;
   logic signed [63:0] s12_quad_in, s12_quad_ff;
   logic signed [63:0] s12_ol_in, s12_ol_ff;
   logic signed [63:0] s13_sum_in, s13_sum_ff;
   logic [67:0]        s14_s25;
   logic [27:0]        s14_mag;
   logic [24:0]        s14_press_in;
   logic               s14_pflag_in;
   logic signed [15:0] rsp_temp_ff;
   logic [24:0]        rsp_press_ff;
   logic               rsp_flag_ff;

   // Write calibration registers; drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         p1p2_ff       <= '0;
         p3p4_ff       <= '0;
         p5p6_ff       <= '0;
         p7p8_ff       <= '0;
         p9_ff         <= '0;
         p10p11_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ptc_pkg::CSR_TEMP_CALIB: temp_calib_ff <= csr_wdata[39:0];
            ptc_pkg::CSR_P1_P2:      p1p2_ff       <= csr_wdata[31:0];
            ptc_pkg::CSR_P3_P4:      p3p4_ff       <= csr_wdata[15:0];
            ptc_pkg::CSR_P5_P6:      p5p6_ff       <= csr_wdata[31:0];
            ptc_pkg::CSR_P7_P8:      p7p8_ff       <= csr_wdata[15:0];
            ptc_pkg::CSR_P9:         p9_ff         <= csr_wdata[15:0];
            ptc_pkg::CSR_P10_P11:    p10p11_ff     <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Unpack coefficients
   assign t1  = temp_calib_ff[15:0];
   assign t2  = temp_calib_ff[31:16];
   assign t3  = temp_calib_ff[39:32];
   assign p1  = p1p2_ff[15:0];
   assign p2  = p1p2_ff[31:16];
   assign p3  = p3p4_ff[7:0];
   assign p4  = p3p4_ff[15:8];
   assign p5  = p5p6_ff[15:0];
   assign p6  = p5p6_ff[31:16];
   assign p7  = p7p8_ff[7:0];
   assign p8  = p7p8_ff[15:8];
   assign p9  = p9_ff;
   assign p10 = p10p11_ff[7:0];
   assign p11 = p10p11_ff[15:8];
   assign p1m = p1 - 17'sd16384;
   assign p2m = p2 - 17'sd16384;

   // Advance all stages unless the response register is held
   assign adv       = !vld_ff[ptc_pkg::STAGES-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[ptc_pkg::STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ptc_pkg::STAGES-2:0], req_valid};
      end
   end

   // Stage 1: offset raw temperature, first products
   assign s1_a_in  = $signed({2'b00, req_raw_temperature}) - $signed({2'b00, t1, 8'h00});
   assign s1_ta_in = $signed({1'b0, t2}) * s1_a_in;
   assign s1_aa_in = s1_a_in * s1_a_in;

   // Stage 2: fine temperature numerator
   assign s2_x_in = (s1_ta_ff <<< 18) + (s1_aa_ff * t3);

   // Stage 3: divide by 2^32 toward zero
   assign s3_xa    = s2_x_ff + (s2_x_ff[61] ? 62'sd4294967295 : 62'sd0);
   assign s3_tl_in = s3_xa[61:32];

   // Stage 4: square, temperature output, linear pressure terms
   assign s4_sq_in = s3_tl_ff * s3_tl_ff;
   assign s4_tc25  = s3_tl_ff * 36'sd25;
   assign s4_tca   = s4_tc25 + (s4_tc25[35] ? 36'sd16383 : 36'sd0);
   assign s4_tc    = s4_tca[35:14];

   always_comb begin
      if (s4_tc > 22'sd32767) begin
         s4_temp_in  = ptc_pkg::TEMP_MAX;
         s4_tflag_in = 1'b1;
      end else if (s4_tc < -22'sd32768) begin
         s4_temp_in  = ptc_pkg::TEMP_MIN;
         s4_tflag_in = 1'b1;
      end else begin
         s4_temp_in  = s4_tc[15:0];
         s4_tflag_in = 1'b0;
      end
   end

   assign s4_p6tl_in = $signed({1'b0, p6}) * s3_tl_ff;
   assign s4_p2tl_in = p2m * s3_tl_ff;
   assign s4_pq_in   = (p10 * s3_tl_ff) + (p9 <<< 16);

   // Stage 5: cube partial products, square terms, quadratic product
   assign s5_pl_in   = $signed({1'b0, s4_sq_ff[29:6]}) * s4_tl_ff;
   assign s5_ph_in   = $signed({1'b0, s4_sq_ff[53:30]}) * s4_tl_ff;
   assign s5_p7sq_in = p7 * s4_sq_ff;
   assign s5_p3sq_in = p3 * s4_sq_ff;
   assign s5_qx_in   = s4_pq_ff * $signed({1'b0, rp_pipe_ff[4]});
   assign s5_rr_in   = rp_pipe_ff[4] * rp_pipe_ff[4];

   // Stage 6: combine cube, split quadratic sign and magnitude
   assign s6_cprod    = s5_pl_ff + (s5_ph_ff <<< 24);
   assign s6_cadj     = s6_cprod + (s6_cprod[63] ? 64'sd255 : 64'sd0);
   assign s6_cube_in  = s6_cadj[63:8];
   assign s6_qabs     = s5_qx_ff[63] ? (64'd0 - s5_qx_ff) : s5_qx_ff;
   assign s6_m_in     = s6_qabs[59:13];
   assign s6_p11rr_in = p11 * $signed({1'b0, s5_rr_ff});

   // Stage 7: cube coefficients, reciprocal partials, cubic scale
   assign s7_p8c_in = p8 * s6_cube_ff;
   assign s7_p4c_in = p4 * s6_cube_ff;
   assign s7_pll_in = s6_m_ff[23:0] * ptc_pkg::RECIP_TEN[23:0];
   assign s7_plh_in = s6_m_ff[23:0] * ptc_pkg::RECIP_TEN[47:24];
   assign s7_phl_in = s6_m_ff[46:24] * ptc_pkg::RECIP_TEN[23:0];
   assign s7_phh_in = s6_m_ff[46:24] * ptc_pkg::RECIP_TEN[47:24];
   assign s7_p11adj = s6_p11rr_ff + (s6_p11rr_ff[56] ? 57'sd65535 : 57'sd0);
   assign s7_c1_in  = s7_p11adj[56:16];

   // Stage 8: scale cube terms, finish divide by ten, cubic product
   assign s8_p8a      = s7_p8c_ff + (s7_p8c_ff[63] ? 64'sd31 : 64'sd0);
   assign s8_p4a      = s7_p4c_ff + (s7_p4c_ff[63] ? 64'sd31 : 64'sd0);
   assign s8_p8c32_in = s8_p8a[63:5];
   assign s8_p4c32_in = s8_p4a[63:5];
   assign s8_rsum     = {47'd0, s7_pll_ff} + ({47'd0, s7_plh_ff} << 24)
                      + ({48'd0, s7_phl_ff} << 24) + ({48'd0, s7_phh_ff} << 48);
   assign s8_q_in     = s8_rsum[94:51];
   assign s8_c1rp_in  = s7_c1_ff * $signed({1'b0, rp_pipe_ff[7]});

   // Stage 9: offset and sensitivity sums
   assign s9_offs_in = $signed({1'b0, p5, 47'd0}) + s8_p8c32_ff
                     + (p7sq_pipe_ff[8] <<< 4) + (p6tl_pipe_ff[8] <<< 22);
   assign s9_sens_in = (p1m <<< 46) + s8_p4c32_ff
                     + (p3sq_pipe_ff[8] <<< 2) + (p2tl_pipe_ff[8] <<< 21);
   assign s9_qrp_in  = s8_q_ff * rp_pipe_ff[8];
   assign s9_ca      = s8_c1rp_ff + (s8_c1rp_ff[63] ? 64'sd127 : 64'sd0);

   // Stage 10: restore quadratic sign, scale offset and sensitivity
   assign s10_qv_in  = qneg_pipe_ff[9] ? (64'd0 - s9_qrp_ff) : s9_qrp_ff;
   assign s10_oa     = s9_offs_ff + (s9_offs_ff[63] ? 64'sd3 : 64'sd0);
   assign s10_sa     = s9_sens_ff + (s9_sens_ff[63] ? 64'sd16777215 : 64'sd0);
   assign s10_s24_in = s10_sa[63:24];

   // Stage 11: quadratic divide by 512, linear term
   assign s11_qva    = s10_qv_ff + (s10_qv_ff[63] ? 64'd511 : 64'd0);
   assign s11_q3_in  = s11_qva[63:9];
   assign s11_lin_in = s10_s24_ff * $signed({1'b0, rp_pipe_ff[10]});

   // Stage 12: times ten, first partial sum
   assign s12_quad_in = (s11_q3_ff <<< 3) + (s11_q3_ff <<< 1);
   assign s12_ol_in   = offs4_pipe_ff[11] + s11_lin_ff;

   // Stage 13: final sum
   assign s13_sum_in = s12_ol_ff + s12_quad_ff + cub_pipe_ff[12];

   // Stage 14: scale by 25/2^40 and saturate
   assign s14_s25 = {s13_sum_ff, 4'd0} + {1'b0, s13_sum_ff, 3'd0} + {4'd0, s13_sum_ff};
   assign s14_mag = s14_s25[67:40];

   always_comb begin
      if (s13_sum_ff[63]) begin
         s14_press_in = '0;
         s14_pflag_in = 1'b1;
      end else if (s14_mag > {3'd0, ptc_pkg::PRESS_MAX}) begin
         s14_press_in = ptc_pkg::PRESS_MAX;
         s14_pflag_in = 1'b1;
      end else begin
         s14_press_in = s14_mag[24:0];
         s14_pflag_in = 1'b0;
      end
   end

   // Advance datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         rp_pipe_ff[1] <= req_raw_pressure;
         for (int i = 2; i <= 10; i++) rp_pipe_ff[i] <= rp_pipe_ff[i-1];
         temp_pipe_ff[4]  <= s4_temp_in;
         tflag_pipe_ff[4] <= s4_tflag_in;
         for (int i = 5; i <= 13; i++) begin
            temp_pipe_ff[i]  <= temp_pipe_ff[i-1];
            tflag_pipe_ff[i] <= tflag_pipe_ff[i-1];
         end
         qneg_pipe_ff[6] <= s5_qx_ff[63];
         for (int i = 7; i <= 9; i++) qneg_pipe_ff[i] <= qneg_pipe_ff[i-1];
         p6tl_pipe_ff[4] <= s4_p6tl_in;
         p2tl_pipe_ff[4] <= s4_p2tl_in;
         for (int i = 5; i <= 8; i++) begin
            p6tl_pipe_ff[i] <= p6tl_pipe_ff[i-1];
            p2tl_pipe_ff[i] <= p2tl_pipe_ff[i-1];
         end
         p7sq_pipe_ff[5] <= s5_p7sq_in;
         p3sq_pipe_ff[5] <= s5_p3sq_in;
         for (int i = 6; i <= 8; i++) begin
            p7sq_pipe_ff[i] <= p7sq_pipe_ff[i-1];
            p3sq_pipe_ff[i] <= p3sq_pipe_ff[i-1];
         end
         cub_pipe_ff[9] <= s9_ca[63:7];
         for (int i = 10; i <= 12; i++) cub_pipe_ff[i] <= cub_pipe_ff[i-1];
         offs4_pipe_ff[10] <= s10_oa[63:2];
         offs4_pipe_ff[11] <= offs4_pipe_ff[10];

         s1_ta_ff    <= s1_ta_in;
         s1_aa_ff    <= s1_aa_in;
         s2_x_ff     <= s2_x_in;
         s3_tl_ff    <= s3_tl_in;
         s4_sq_ff    <= s4_sq_in;
         s4_tl_ff    <= s3_tl_ff;
         s4_pq_ff    <= s4_pq_in;
         s5_pl_ff    <= s5_pl_in;
         s5_ph_ff    <= s5_ph_in;
         s5_qx_ff    <= s5_qx_in;
         s5_rr_ff    <= s5_rr_in;
         s6_cube_ff  <= s6_cube_in;
         s6_m_ff     <= s6_m_in;
         s6_p11rr_ff <= s6_p11rr_in;
         s7_p8c_ff   <= s7_p8c_in;
         s7_p4c_ff   <= s7_p4c_in;
         s7_pll_ff   <= s7_pll_in;
         s7_plh_ff   <= s7_plh_in;
         s7_phl_ff   <= s7_phl_in;
         s7_phh_ff   <= s7_phh_in;
         s7_c1_ff    <= s7_c1_in;
         s8_p8c32_ff <= s8_p8c32_in;
         s8_p4c32_ff <= s8_p4c32_in;
         s8_q_ff     <= s8_q_in;
         s8_c1rp_ff  <= s8_c1rp_in;
         s9_offs_ff  <= s9_offs_in;
         s9_sens_ff  <= s9_sens_in;
         s9_qrp_ff   <= s9_qrp_in;
         s10_qv_ff   <= s10_qv_in;
         s10_s24_ff  <= s10_s24_in;
         s11_q3_ff   <= s11_q3_in;
         s11_lin_ff  <= s11_lin_in;
         s12_quad_ff <= s12_quad_in;
         s12_ol_ff   <= s12_ol_in;
         s13_sum_ff  <= s13_sum_in;
         rsp_temp_ff  <= temp_pipe_ff[13];
         rsp_press_ff <= s14_press_in;
         rsp_flag_ff  <= s14_pflag_in | tflag_pipe_ff[13];
      end
   end

   assign rsp_temperature_centi_c = rsp_temp_ff;
   assign rsp_pressure_centi_pa   = rsp_press_ff;
   assign rsp_out_of_range        = rsp_flag_ff;

endmodule
`default_nettype wire

FILE: hdl/ptc_checker.sv
// Port-level checker for the compensation block, bound to the top level.
`default_nettype none
`include "pressure_temperature_compensation_defines.svh"
module ptc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_temperature_centi_c,
   input wire logic [24:0] rsp_pressure_centi_pa,
   input wire logic        rsp_out_of_range
);

   // Empty pipe after reset
   `PTC_ASSERT_RAW(a_reset_empty, reset |=> !rsp_valid, "response valid right after reset")

   // Hold a stalled response
   `PTC_ASSERT_ALWAYS(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_temperature_centi_c) && $stable(rsp_pressure_centi_pa) && $stable(rsp_out_of_range)), "stalled response changed")

   // Back-pressure the request side while the response is stalled
   `PTC_ASSERT_ALWAYS(a_backpressure, (rsp_valid && !rsp_ready) |-> !req_ready, "request taken during response stall")

   // Accept requests whenever the response slot is empty
   `PTC_ASSERT_ALWAYS(a_ready_empty, !rsp_valid |-> req_ready, "request refused with empty output")

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);
`default_nettype wire
